// File: rtl/mdag_pkg.sv
// ----------------------------------------------------------------------------
// mdag_pkg - shared definitions for the array address generator
// Field widths, item modes, controller states and the multiply-accumulate
// control bundle.
// ----------------------------------------------------------------------------
package mdag_pkg;

    localparam int NUM_ARRAYS_DEF = 16;
    localparam int MAX_DIMS_DEF   = 10;

    localparam int MODE_W  = 2;
    localparam int ID_W    = 4;
    localparam int DIM_W   = 4;
    localparam int BASE_W  = 32;
    localparam int ELEM_W  = 16;
    localparam int BOUND_W = 32;
    localparam int ADDR_W  = 64;
    localparam int HALF_W  = 32;

    // header entry: {base, element size, dimension count}
    localparam int HDR_W = BASE_W + ELEM_W + DIM_W;
    // bounds entry: {upper, lower}
    localparam int BND_W = 2 * BOUND_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_HDR = 2'd0,
        MODE_BND = 2'd1,
        MODE_REF = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OFFSET,
        S_ADDR
    } state_t;

    typedef struct packed {
        logic              load;
        logic [ADDR_W-1:0] load_val;
        logic [HALF_W-1:0] mul_a;
        logic [HALF_W-1:0] mul_b;
        logic              mul_hi;
        logic              add_en;
    } mac_ctl_t;

endpackage

// File: rtl/mdag_if.sv
// ----------------------------------------------------------------------------
// mdag_if - valid/ready channels of the array address generator
// Request channel carries descriptor writes and subscripts; response channel
// carries completed element addresses.
// ----------------------------------------------------------------------------
interface mdag_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [mdag_pkg::MODE_W-1:0]           mode;
    logic [mdag_pkg::ID_W-1:0]             array_id;
    logic [mdag_pkg::DIM_W-1:0]            dim;
    logic [mdag_pkg::BASE_W-1:0]           base_addr;
    logic [mdag_pkg::ELEM_W-1:0]           elem_bytes;
    logic [mdag_pkg::DIM_W-1:0]            dim_count;
    logic signed [mdag_pkg::BOUND_W-1:0]   lower;
    logic signed [mdag_pkg::BOUND_W-1:0]   upper;
    logic signed [mdag_pkg::BOUND_W-1:0]   index_val;

    modport source (
        output valid, mode, array_id, dim, base_addr, elem_bytes, dim_count,
               lower, upper, index_val,
        input  ready
    );
    modport sink (
        input  valid, mode, array_id, dim, base_addr, elem_bytes, dim_count,
               lower, upper, index_val,
        output ready
    );
endinterface

interface mdag_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mdag_pkg::ADDR_W-1:0]   address;
    logic [mdag_pkg::ID_W-1:0]            ref_array;

    modport source (
        output valid, address, ref_array,
        input  ready
    );
    modport sink (
        input  valid, address, ref_array,
        output ready
    );
endinterface

// File: rtl/multidim_array_address_gen_top.sv
// ----------------------------------------------------------------------------
// multidim_array_address_gen_top - row-major element address generator
// Keeps array descriptors in two RAMs and turns subscripts into addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transfer. A header item stores base address,
//   element size and dimension count for array_id; a bounds item stores the
//   lower and upper bound of one dimension. A reference is a run of index
//   items for dimensions 1..D of one array, in order.
//   rsp carries {address, ref_array} once the index for the last dimension
//   has been folded in: base + offset * element size, modulo 2^64.
// Sequence:
//   Header and bounds items, and items that are dropped, are taken in idle.
//   A subscript goes through accept, descriptor read, then the offset state,
//   where the single shared 32x32 multiplier forms offset * extent from three
//   partial products. The last subscript then forms offset * element size in
//   the address state; its result is registered onto rsp.
// Reset:
//   Clears the controller, the running offset and rsp.valid. Descriptor
//   RAMs are not cleared; a reference to an unwritten descriptor is invalid.
// Stall:
//   rsp holds one result. Further items are taken while it waits; only the
//   last subscript of the next reference holds before its final multiply
//   until rsp is free.
// ----------------------------------------------------------------------------
module multidim_array_address_gen_top #(
    parameter int NUM_ARRAYS = mdag_pkg::NUM_ARRAYS_DEF,
    parameter int MAX_DIMS   = mdag_pkg::MAX_DIMS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mdag_in_if.sink       req,
    mdag_out_if.source    rsp
);

    localparam int HDR_DEPTH = NUM_ARRAYS;
    localparam int BND_DEPTH = NUM_ARRAYS * MAX_DIMS;
    localparam int HDR_AW    = (HDR_DEPTH > 1) ? $clog2(HDR_DEPTH) : 1;
    localparam int BND_AW    = (BND_DEPTH > 1) ? $clog2(BND_DEPTH) : 1;
    localparam int AW        = mdag_pkg::ADDR_W;
    localparam int HW        = mdag_pkg::HALF_W;

    // ---------------------------------------------------------------- state
    mdag_pkg::state_t               state_reg, state_next;
    logic [1:0]                     step_reg, step_next;
    logic [AW-1:0]                  acc_reg, acc_next;
    logic [AW-1:0]                  ext_reg;
    logic [mdag_pkg::ID_W-1:0]      id_reg;
    logic [mdag_pkg::DIM_W-1:0]     dim_reg;
    logic [mdag_pkg::BOUND_W-1:0]   idx_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [AW-1:0]                  out_addr_reg;
    logic [mdag_pkg::ID_W-1:0]      out_id_reg;

    // -------------------------------------------------------- request decode
    logic                    accept;
    logic                    id_ok, dim_ok;
    logic [31:0]             id_full, slot_full;
    logic [HDR_AW-1:0]       hdr_addr;
    logic [BND_AW-1:0]       bnd_addr;
    logic [mdag_pkg::DIM_W-1:0] dc_sat;

    assign accept    = req.valid && req.ready;
    assign id_full   = 32'(req.array_id);
    assign id_ok     = id_full < NUM_ARRAYS;
    assign dim_ok    = (req.dim != '0) && (32'(req.dim) <= MAX_DIMS);
    assign slot_full = id_full * MAX_DIMS + 32'(req.dim) - 32'd1;
    assign hdr_addr  = id_full[HDR_AW-1:0];
    assign bnd_addr  = slot_full[BND_AW-1:0];
    assign dc_sat    = (32'(req.dim_count) > MAX_DIMS) ? mdag_pkg::DIM_W'(MAX_DIMS)
                                                       : req.dim_count;

    // ------------------------------------------------------- descriptor RAMs
    logic                        hdr_we, bnd_we, rd_en;
    logic [mdag_pkg::HDR_W-1:0]  hdr_rd;
    logic [mdag_pkg::BND_W-1:0]  bnd_rd;
    logic [mdag_pkg::BASE_W-1:0] hdr_base;
    logic [mdag_pkg::ELEM_W-1:0] hdr_elem;
    logic [mdag_pkg::DIM_W-1:0]  hdr_dims;

    mdag_ram #(.WIDTH(mdag_pkg::HDR_W), .DEPTH(HDR_DEPTH)) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_we),
        .wr_addr (hdr_addr),
        .wr_data ({req.base_addr, req.elem_bytes, dc_sat}),
        .rd_en   (rd_en),
        .rd_addr (hdr_addr),
        .rd_data (hdr_rd)
    );

    mdag_ram #(.WIDTH(mdag_pkg::BND_W), .DEPTH(BND_DEPTH)) u_bnd_ram (
        .clk     (clk),
        .wr_en   (bnd_we),
        .wr_addr (bnd_addr),
        .wr_data ({req.upper, req.lower}),
        .rd_en   (rd_en),
        .rd_addr (bnd_addr),
        .rd_data (bnd_rd)
    );

    // read data holds while rd_en is low, so the header stays usable
    assign {hdr_base, hdr_elem, hdr_dims} = hdr_rd;

    // --------------------------------------------- extent and index offset
    logic [AW-1:0] lo64, up64, idx64, ext_calc, diff_calc;

    assign lo64      = {{HW{bnd_rd[HW-1]}}, bnd_rd[HW-1:0]};
    assign up64      = {{HW{bnd_rd[2*HW-1]}}, bnd_rd[2*HW-1:HW]};
    assign idx64     = {{HW{idx_reg[HW-1]}}, idx_reg};
    assign ext_calc  = up64 - lo64 + 64'd1;
    assign diff_calc = idx64 - lo64;

    // ------------------------------------------------- multiply-accumulate
    mdag_pkg::mac_ctl_t mac_ctl;
    logic [AW-1:0]      sum_next;

    mdag_mac u_mdag_mac (
        .clk      (clk),
        .ctl      (mac_ctl),
        .sum_next (sum_next)
    );

    logic last_dim, out_free, ext_load;

    assign last_dim = (dim_reg == hdr_dims);
    assign out_free = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            mdag_pkg::S_IDLE:
            begin
                if (accept && id_ok && dim_ok && (req.mode == mdag_pkg::MODE_REF))
                begin
                    state_next = mdag_pkg::S_READ;
                end
            end
            mdag_pkg::S_READ:
            begin
                state_next = mdag_pkg::S_OFFSET;
                step_next  = 2'd0;
            end
            mdag_pkg::S_OFFSET:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = last_dim ? mdag_pkg::S_ADDR : mdag_pkg::S_IDLE;
                    step_next  = 2'd0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            mdag_pkg::S_ADDR:
            begin
                priority if (step_reg == 2'd2)
                begin
                    state_next = mdag_pkg::S_IDLE;
                    step_next  = 2'd0;
                end
                else if ((step_reg != 2'd0) || out_free)
                begin
                    // hold before the first product until rsp can take the result
                    step_next = step_reg + 2'd1;
                end
                else
                begin
                    step_next = step_reg;
                end
            end
            default:
            begin
                state_next = mdag_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------- outputs
    always_comb
    begin
        req.ready        = 1'b0;
        hdr_we           = 1'b0;
        bnd_we           = 1'b0;
        rd_en            = 1'b0;
        ext_load         = 1'b0;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        mac_ctl          = '0;
        unique case (state_reg)
            mdag_pkg::S_IDLE:
            begin
                // ready is high here, so valid alone marks a transfer
                req.ready = 1'b1;
                rd_en     = 1'b1;
                hdr_we    = req.valid && id_ok && (req.mode == mdag_pkg::MODE_HDR);
                bnd_we    = req.valid && id_ok && dim_ok && (req.mode == mdag_pkg::MODE_BND);
            end
            mdag_pkg::S_READ:
            begin
                // seed the sum with the index offset; dimension 1 starts afresh
                ext_load         = 1'b1;
                mac_ctl.load     = 1'b1;
                mac_ctl.load_val = diff_calc;
                if (dim_reg == mdag_pkg::DIM_W'(1))
                begin
                    acc_next = '0;
                end
            end
            mdag_pkg::S_OFFSET:
            begin
                // acc * ext modulo 2^64: lo*lo + (lo*hi + hi*lo) << 32
                mac_ctl.add_en = (step_reg != 2'd0);
                unique case (step_reg)
                    2'd0:
                    begin
                        mac_ctl.mul_a = acc_reg[HW-1:0];
                        mac_ctl.mul_b = ext_reg[HW-1:0];
                    end
                    2'd1:
                    begin
                        mac_ctl.mul_a  = acc_reg[HW-1:0];
                        mac_ctl.mul_b  = ext_reg[AW-1:HW];
                        mac_ctl.mul_hi = 1'b1;
                    end
                    2'd2:
                    begin
                        mac_ctl.mul_a  = acc_reg[AW-1:HW];
                        mac_ctl.mul_b  = ext_reg[HW-1:0];
                        mac_ctl.mul_hi = 1'b1;
                    end
                    default:
                    begin
                        acc_next = sum_next;
                        if (last_dim)
                        begin
                            mac_ctl.load     = 1'b1;
                            mac_ctl.load_val = {{HW{1'b0}}, hdr_base};
                        end
                    end
                endcase
            end
            mdag_pkg::S_ADDR:
            begin
                // base + acc * element size
                mac_ctl.add_en = (step_reg != 2'd0);
                mac_ctl.mul_b  = {{(HW - mdag_pkg::ELEM_W){1'b0}}, hdr_elem};
                unique case (step_reg)
                    2'd0:
                    begin
                        mac_ctl.mul_a = acc_reg[HW-1:0];
                    end
                    2'd1:
                    begin
                        mac_ctl.mul_a  = acc_reg[AW-1:HW];
                        mac_ctl.mul_hi = 1'b1;
                    end
                    default:
                    begin
                        acc_next       = '0;
                        out_valid_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // -------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdag_pkg::S_IDLE;
            step_reg      <= 2'd0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg  <= req.array_id;
            dim_reg <= req.dim;
            idx_reg <= req.index_val;
        end
        if (ext_load)
        begin
            ext_reg <= ext_calc;
        end
        if (out_valid_next && !out_valid_reg || out_valid_next && rsp.ready)
        begin
            out_addr_reg <= sum_next;
            out_id_reg   <= id_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.address   = out_addr_reg;
    assign rsp.ref_array = out_id_reg;

endmodule

// File: rtl/mdag_ram.sv
// ----------------------------------------------------------------------------
// mdag_ram - generic simple dual-port RAM
// One write port, one read port with enable; read data registered.
// ----------------------------------------------------------------------------
module mdag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/mdag_mac.sv
// ----------------------------------------------------------------------------
// mdag_mac - shared 32x32 multiplier with 64-bit accumulator
// Registers one partial product a cycle and folds the previous one into the
// running sum, optionally shifted up by 32 bits.
// ----------------------------------------------------------------------------
module mdag_mac (
    input  logic                          clk,
    input  mdag_pkg::mac_ctl_t            ctl,
    output logic [mdag_pkg::ADDR_W-1:0]   sum_next
);

    logic [mdag_pkg::ADDR_W-1:0] prod_reg;
    logic [mdag_pkg::ADDR_W-1:0] prod_next;
    logic                        hi_reg;
    logic [mdag_pkg::ADDR_W-1:0] sum_reg;
    logic [mdag_pkg::ADDR_W-1:0] addend;

    always_comb
    begin
        prod_next = ctl.mul_a * ctl.mul_b;
        if (!ctl.add_en)
        begin
            addend = '0;
        end
        else if (hi_reg)
        begin
            addend = {prod_reg[mdag_pkg::HALF_W-1:0], {mdag_pkg::HALF_W{1'b0}}};
        end
        else
        begin
            addend = prod_reg;
        end
        sum_next = sum_reg + addend;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        hi_reg   <= ctl.mul_hi;
        sum_reg  <= ctl.load ? ctl.load_val : sum_next;
    end

endmodule

// File: rtl/mdag_checker.sv
// ----------------------------------------------------------------------------
// mdag_checker - port-level checks for the array address generator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module mdag_checker #(
    parameter int NUM_ARRAYS = mdag_pkg::NUM_ARRAYS_DEF,
    parameter int MAX_DIMS   = mdag_pkg::MAX_DIMS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic [mdag_pkg::MODE_W-1:0]     req_mode,
    input logic [mdag_pkg::ID_W-1:0]       req_array_id,
    input logic [mdag_pkg::DIM_W-1:0]      req_dim,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [mdag_pkg::ADDR_W-1:0]     rsp_address,
    input logic [mdag_pkg::ID_W-1:0]       rsp_ref_array
);

    logic ref_accept;

    assign ref_accept = req_valid && req_ready && (req_mode == mdag_pkg::MODE_REF)
                        && (32'(req_array_id) < NUM_ARRAYS) && (req_dim != '0)
                        && (32'(req_dim) <= MAX_DIMS);

    // a subscript occupies the multiplier, so the next cycle takes nothing
    a_ref_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ref_accept |=> !req_ready)
        else $error("request accepted while a subscript is in progress");

    // a new result only appears at the end of a subscript's work
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a subscript in progress");

    a_rsp_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_ref_array) < NUM_ARRAYS))
        else $error("result names an array beyond the table");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address)
                                    && $stable(rsp_ref_array))
        else $error("stalled result dropped or changed");

endmodule

bind multidim_array_address_gen_top mdag_checker #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
) u_mdag_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_mode      (req.mode),
    .req_array_id  (req.array_id),
    .req_dim       (req.dim),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_address   (rsp.address),
    .rsp_ref_array (rsp.ref_array)
);
